@@ sv/indrnn_pkg.sv @@
// Shared types, widths and the tanh knot table of the recurrent neuron core.
// Depends on nothing; indrnn_act and indrnn_cell_forward_core import it.
package indrnn_pkg;

	localparam int LANES      = 1024;
	localparam int LANE_WIDTH = 10;
	localparam int ADDR_WIDTH = $clog2(LANES);
	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 12;
	localparam int PROD_WIDTH = 2 * DATA_WIDTH;
	localparam int KNOT_WIDTH = 13;
	localparam int FRAC_WIDTH = 11;
	localparam int IDX_WIDTH  = 5;

	localparam logic [IDX_WIDTH-1:0]  TANH_LAST_IDX = 5'd16;
	localparam logic [KNOT_WIDTH-1:0] TANH_ONE      = 13'd4096;

	localparam logic ACT_RELU = 1'b0;
	localparam logic ACT_TANH = 1'b1;

	typedef struct packed {
		logic [LANE_WIDTH-1:0]        lane;
		logic signed [DATA_WIDTH-1:0] sample;
		logic signed [DATA_WIDTH-1:0] weight;
		logic signed [DATA_WIDTH-1:0] initial_hidden;
		logic                         first_step;
	} req_beat_t;

	typedef struct packed {
		logic [LANE_WIDTH-1:0]        out_lane;
		logic signed [DATA_WIDTH-1:0] hidden_out;
		logic                         saturated;
	} rsp_beat_t;

	// Knots of tanh sampled every 0.5, scaled by 4096.
	function automatic logic [KNOT_WIDTH-1:0] tanh_knot(input logic [IDX_WIDTH-1:0] k);
		logic [KNOT_WIDTH-1:0] v;
		case (k)
			5'd0:    v = 13'd0;
			5'd1:    v = 13'd1893;
			5'd2:    v = 13'd3119;
			5'd3:    v = 13'd3707;
			5'd4:    v = 13'd3949;
			5'd5:    v = 13'd4041;
			5'd6:    v = 13'd4076;
			5'd7:    v = 13'd4089;
			5'd8:    v = 13'd4093;
			5'd9:    v = 13'd4095;
			default: v = TANH_ONE;
		endcase
		return v;
	endfunction

endpackage

@@ sv/indrnn_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// Read-first on a same-address collision. No dependencies.
module indrnn_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/indrnn_act.sv @@
// Activation unit: ReLU or piecewise-linear odd tanh on a saturated Q4.12 sum.
// Depends on indrnn_pkg for widths and the knot table.
module indrnn_act import indrnn_pkg::*; (
	input  logic                         act_sel,
	input  logic signed [DATA_WIDTH-1:0] x,
	output logic signed [DATA_WIDTH-1:0] y
);

	logic                    neg;
	logic [DATA_WIDTH:0]     mag_wide;
	logic [DATA_WIDTH-1:0]   mag;
	logic [IDX_WIDTH-1:0]    idx;
	logic [FRAC_WIDTH-1:0]   frac;
	logic [KNOT_WIDTH-1:0]   knot_lo;
	logic [KNOT_WIDTH-1:0]   knot_hi;
	logic [KNOT_WIDTH-1:0]   delta;
	logic [KNOT_WIDTH+FRAC_WIDTH-1:0] interp;
	logic [KNOT_WIDTH-1:0]   step;
	logic [KNOT_WIDTH-1:0]   tmag;
	logic signed [DATA_WIDTH-1:0] tanh_y;
	logic signed [DATA_WIDTH-1:0] relu_y;

	always_comb begin
		neg      = x[DATA_WIDTH-1];
		mag_wide = neg ? (-{x[DATA_WIDTH-1], x}) : {x[DATA_WIDTH-1], x};
		// The magnitude of the most negative code still fits as unsigned.
		mag      = mag_wide[DATA_WIDTH-1:0];
		idx      = mag[DATA_WIDTH-1:FRAC_WIDTH];
		frac     = mag[FRAC_WIDTH-1:0];
		knot_lo  = tanh_knot(idx);
		knot_hi  = tanh_knot(idx + 5'd1);
		delta    = knot_hi - knot_lo;
		interp   = ({{FRAC_WIDTH{1'b0}}, delta} * {{KNOT_WIDTH{1'b0}}, frac})
		         + (KNOT_WIDTH+FRAC_WIDTH)'(1024);
		step     = interp[KNOT_WIDTH+FRAC_WIDTH-1:FRAC_WIDTH];
		if (idx >= TANH_LAST_IDX) begin
			tmag = TANH_ONE;
		end else begin
			tmag = knot_lo + step;
		end
		tanh_y = neg ? -$signed({{(DATA_WIDTH-KNOT_WIDTH){1'b0}}, tmag})
		             :  $signed({{(DATA_WIDTH-KNOT_WIDTH){1'b0}}, tmag});
		relu_y = neg ? '0 : x;
		y      = (act_sel == ACT_TANH) ? tanh_y : relu_y;
	end

endmodule

@@ sv/indrnn_cell_forward_core.sv @@
// An accepted beat passes through stages 1, 2 and 3 and then into the output register.
// Throughput: one beat per cycle while neither a lane hazard nor a stalled output holds the pipeline.
// A non-first beat whose lane matches a beat still in stage 1 or 2 waits,
// because its previous hidden value comes out of the activation stage only once that beat is in stage 3.
// Reset clears the valid flags and the activation select; the hidden RAM is not cleared.
// Depends on indrnn_pkg, indrnn_ram and indrnn_act.
module indrnn_cell_forward_core import indrnn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req_beat,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp_beat,
	input  logic      cfg_we,
	input  logic      cfg_data
);

	// The pipeline moves as one: every stage advances whenever the output
	// register is empty or its beat is being taken this cycle.
	logic advance;
	logic hazard;
	logic accept;

	logic act_sel_q;

	// Stage 1: the beat itself, while the RAM read for its lane completes.
	logic      v_s1;
	req_beat_t beat_s1;

	// Stage 2: the product weight * previous hidden value.
	logic                         v_s2;
	logic [LANE_WIDTH-1:0]        lane_s2;
	logic signed [DATA_WIDTH-1:0] sample_s2;
	logic signed [PROD_WIDTH-1:0] prod_s2;

	// Stage 3: the saturated pre-activation sum.
	logic                         v_s3;
	logic [LANE_WIDTH-1:0]        lane_s3;
	logic signed [DATA_WIDTH-1:0] sum_s3;
	logic                         sat_s3;

	// The output register doubles as the fourth stage.
	logic      rsp_valid_q;
	rsp_beat_t rsp_beat_q;

	logic [DATA_WIDTH-1:0]        ram_rdata;
	logic signed [DATA_WIDTH-1:0] prev_s1;
	logic                         fwd_hit;
	logic signed [PROD_WIDTH-1:0] prod_next;

	logic signed [PROD_WIDTH:0]   biased;
	logic signed [PROD_WIDTH-FRAC_BITS:0] rounded;
	logic signed [PROD_WIDTH-FRAC_BITS+1:0] total;
	logic signed [DATA_WIDTH-1:0] sum_next;
	logic                         sat_next;

	logic signed [DATA_WIDTH-1:0] h_s3;

	assign advance = !rsp_valid_q || !rsp_stall;

	// A beat that needs the stored hidden value may not enter while an older
	// beat on the same lane sits in stage 1 or 2: their results are not yet
	// written and cannot be forwarded in time. A beat in stage 3 writes the
	// RAM on the very edge this beat enters, and is forwarded from the output
	// register in the next cycle.
	assign hazard = req_valid && !req_beat.first_step
	             && ((v_s1 && beat_s1.lane == req_beat.lane)
	             ||  (v_s2 && lane_s2 == req_beat.lane));

	assign req_stall = !advance || hazard;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_sel_q <= ACT_RELU;
		end else if (cfg_we) begin
			act_sel_q <= cfg_data;
		end
	end

	// Hidden state RAM. LANES equals 2**LANE_WIDTH, so the lane is the address.
	indrnn_ram #(
		.ADDR_W(ADDR_WIDTH),
		.DATA_W(DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (advance && v_s3),
		.waddr (lane_s3[ADDR_WIDTH-1:0]),
		.wdata (h_s3),
		.re    (accept),
		.raddr (req_beat.lane[ADDR_WIDTH-1:0]),
		.rdata (ram_rdata)
	);

	// Because all stages move together, the output register always holds the
	// beat that left stage 3 on the edge the stage 1 beat was read.
	assign fwd_hit = rsp_valid_q && (rsp_beat_q.out_lane == beat_s1.lane);

	always_comb begin
		if (beat_s1.first_step) begin
			prev_s1 = beat_s1.initial_hidden;
		end else if (fwd_hit) begin
			prev_s1 = rsp_beat_q.hidden_out;
		end else begin
			prev_s1 = $signed(ram_rdata);
		end
		prod_next = beat_s1.weight * prev_s1;
	end

	// Round half up to twelve fractional bits, add the sample and clip.
	always_comb begin
		biased   = {prod_s2[PROD_WIDTH-1], prod_s2} + (PROD_WIDTH+1)'(1 << (FRAC_BITS - 1));
		rounded  = biased[PROD_WIDTH:FRAC_BITS];
		total    = {{(PROD_WIDTH-FRAC_BITS-DATA_WIDTH+2){sample_s2[DATA_WIDTH-1]}}, sample_s2}
		         + {rounded[PROD_WIDTH-FRAC_BITS], rounded};
		sat_next = 1'b0;
		sum_next = total[DATA_WIDTH-1:0];
		if (!total[PROD_WIDTH-FRAC_BITS+1]
		    && (total[PROD_WIDTH-FRAC_BITS:DATA_WIDTH-1] != '0)) begin
			sum_next = {1'b0, {(DATA_WIDTH-1){1'b1}}};
			sat_next = 1'b1;
		end else if (total[PROD_WIDTH-FRAC_BITS+1]
		    && (total[PROD_WIDTH-FRAC_BITS:DATA_WIDTH-1] != '1)) begin
			sum_next = {1'b1, {(DATA_WIDTH-1){1'b0}}};
			sat_next = 1'b1;
		end
	end

	indrnn_act u_act (
		.act_sel (act_sel_q),
		.x       (sum_s3),
		.y       (h_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= accept;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			rsp_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			beat_s1               <= req_beat;
			lane_s2               <= beat_s1.lane;
			sample_s2             <= beat_s1.sample;
			prod_s2               <= prod_next;
			lane_s3               <= lane_s2;
			sum_s3                <= sum_next;
			sat_s3                <= sat_next;
			rsp_beat_q.out_lane   <= lane_s3;
			rsp_beat_q.hidden_out <= h_s3;
			rsp_beat_q.saturated  <= sat_s3;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_beat  = rsp_beat_q;

	// An accepted beat is in stage 1 right after.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted beat did not reach stage 1");

	// A stage 1 beat that reads the store never shares a lane with a beat
	// whose result has not been written yet.
	a_no_raw: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !beat_s1.first_step) |->
		(!(v_s2 && lane_s2 == beat_s1.lane) && !(v_s3 && lane_s3 == beat_s1.lane)))
		else $error("read-after-write hazard on a lane in flight");

	// A new result appears only from a beat that was in stage 3.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(v_s3))
		else $error("result appeared without a stage 3 beat");

endmodule
